[hdl/mwpm_pkg.sv]
package mwpm_pkg;

   localparam int ENTRIES_DEFAULT = 64;
   localparam int PACKETS_DEFAULT = 32;

   localparam logic [2:0] ACT_GET_INPUT  = 3'd0;
   localparam logic [2:0] ACT_GET_OUTPUT = 3'd1;
   localparam logic [2:0] ACT_RETURN     = 3'd2;
   localparam logic [2:0] ACT_PUSH       = 3'd3;
   localparam logic [2:0] ACT_POP        = 3'd4;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NO_PACKET   = 2'd1;
   localparam logic [1:0] ST_FULL        = 2'd2;
   localparam logic [1:0] ST_EMPTY       = 2'd3;

   localparam logic [1:0] POOL_EMPTY     = 2'd0;
   localparam logic [1:0] POOL_PARTIAL   = 2'd1;
   localparam logic [1:0] POOL_FULL      = 2'd2;

endpackage

[hdl/mark_work_packet_manager.sv]
// Each item goes through the packet table read (S_TBL) and, for a pop that returns an entry,
// a second read of the entry memory (S_ENT); the result is registered when the item commits.
// One item at a time: the next is taken only once the previous one commits, limited by the
// packet table read-modify-write; a stalled result output holds the commit.
// Reset (synchronous) starts a table init pass over all PACKET_TOTAL entries that rebuilds
// the empty-pool chain and zeroes every fill; no item is accepted until it finishes.
module mark_work_packet_manager import mwpm_pkg::*; #(
   parameter int ENTRIES_PER_PACKET = ENTRIES_DEFAULT,
   parameter int PACKET_TOTAL       = PACKETS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // packet_id[4:0], entry_value[68:5], zero pad
   input  logic [2:0]  req_tuser,  // action[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // granted_packet[4:0], popped_value[68:5],
                                   // fill_level[75:69], all_empty[76], zero pad
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   localparam int ID_W    = (PACKET_TOTAL > 1) ? $clog2(PACKET_TOTAL) : 1;
   localparam int CNT_W   = $clog2(PACKET_TOTAL + 1);
   localparam int FILL_W  = $clog2(ENTRIES_PER_PACKET + 1);
   localparam int TBL_W   = ID_W + FILL_W;
   localparam int EADDR_W = $clog2(PACKET_TOTAL * ENTRIES_PER_PACKET);
   localparam int HALF    = ENTRIES_PER_PACKET / 2;
   localparam int CMP_W   = 11;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_TBL  = 2'd1;
   localparam logic [1:0] S_ENT  = 2'd2;
   localparam logic [1:0] S_CLR  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [ID_W-1:0]    clr_idx_ff, clr_idx_in;
   logic [2:0]         act_ff;
   logic [ID_W-1:0]    id_ff;
   logic [63:0]        value_ff;
   logic               bad_ff;
   logic               take_ok_ff;
   logic [1:0]         src_ff;
   logic [EADDR_W-1:0] base_ff;
   logic [EADDR_W-1:0] ent_ra_ff;

   logic [ID_W-1:0]    empty_head_ff, empty_head_in;
   logic [ID_W-1:0]    part_head_ff, part_head_in;
   logic [ID_W-1:0]    full_head_ff, full_head_in;
   logic [CNT_W-1:0]   empty_cnt_ff, empty_cnt_in;
   logic [CNT_W-1:0]   part_cnt_ff, part_cnt_in;
   logic [CNT_W-1:0]   full_cnt_ff, full_cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [4:0]         rsp_granted_ff, rsp_granted_in;
   logic [63:0]        rsp_popped_ff, rsp_popped_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [6:0]         rsp_fill_ff, rsp_fill_in;
   logic               rsp_all_empty_ff, rsp_all_empty_in;

   logic [2:0]         req_action;
   logic [4:0]         req_packet_id;
   logic [63:0]        req_entry_value;
   logic               req_accept;
   logic               req_bad;
   logic [ID_W+4:0]    req_id_wide;
   logic [ID_W-1:0]    req_id;
   logic               req_is_get;
   logic               req_take_ok;
   logic [1:0]         req_src;
   logic [ID_W-1:0]    req_take_id;

   logic               tbl_we;
   logic [ID_W-1:0]    tbl_wa;
   logic [TBL_W-1:0]   tbl_wd;
   logic [ID_W-1:0]    tbl_ra;
   logic [TBL_W-1:0]   tbl_rd;
   logic [ID_W-1:0]    tbl_link;
   logic [FILL_W-1:0]  tbl_fill;
   logic [ID_W-1:0]    clr_link;

   logic               ent_we;
   logic [EADDR_W-1:0] ent_wa;
   logic [EADDR_W-1:0] ent_ra;
   logic [63:0]        ent_rd;

   logic               out_free;
   logic               fin;
   logic [1:0]         dest;
   logic [FILL_W-1:0]  r_fill;
   logic [FILL_W+6:0]  r_fill_wide;
   logic [ID_W+4:0]    r_gr_wide;

   assign req_packet_id   = req_tdata[4:0];
   assign req_entry_value = req_tdata[68:5];
   assign req_action      = req_tuser;
   assign req_tready      = (state_ff == S_IDLE);
   assign req_accept      = req_tvalid && req_tready;

   assign req_bad     = ({{(CMP_W-5){1'b0}}, req_packet_id} >= CMP_W'(PACKET_TOTAL));
   assign req_id_wide = {{ID_W{1'b0}}, req_packet_id};
   assign req_id      = req_bad ? '0 : req_id_wide[ID_W-1:0];
   assign req_is_get  = (req_action == ACT_GET_INPUT) || (req_action == ACT_GET_OUTPUT);

   // pick the source pool for a get from the live pool counts
   always_comb begin
      req_take_ok = 1'b1;
      req_src     = POOL_PARTIAL;
      req_take_id = part_head_ff;
      if (req_action == ACT_GET_INPUT && full_cnt_ff != '0) begin
         req_src     = POOL_FULL;
         req_take_id = full_head_ff;
      end else if (req_action == ACT_GET_OUTPUT && empty_cnt_ff != '0) begin
         req_src     = POOL_EMPTY;
         req_take_id = empty_head_ff;
      end else if (part_cnt_ff == '0) begin
         req_take_ok = 1'b0;
         req_take_id = '0;
      end
   end

   assign tbl_ra   = (state_ff == S_IDLE) ? (req_is_get ? req_take_id : req_id) : id_ff;
   assign tbl_link = tbl_rd[TBL_W-1:FILL_W];
   assign tbl_fill = tbl_rd[FILL_W-1:0];
   assign clr_link = (clr_idx_ff == '0) ? '0 : clr_idx_ff - 1'b1;
   assign ent_ra   = (state_ff == S_TBL) ? base_ff + EADDR_W'(tbl_fill - 1'b1) : ent_ra_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in         = state_ff;
      clr_idx_in       = clr_idx_ff;
      empty_head_in    = empty_head_ff;
      part_head_in     = part_head_ff;
      full_head_in     = full_head_ff;
      empty_cnt_in     = empty_cnt_ff;
      part_cnt_in      = part_cnt_ff;
      full_cnt_in      = full_cnt_ff;
      tbl_we           = 1'b0;
      tbl_wa           = id_ff;
      tbl_wd           = tbl_rd;
      ent_we           = 1'b0;
      ent_wa           = base_ff + EADDR_W'(tbl_fill);
      fin              = 1'b0;
      dest             = POOL_FULL;
      r_fill           = '0;
      rsp_granted_in   = '0;
      rsp_popped_in    = '0;
      rsp_status_in    = ST_OK;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         S_CLR: begin
            tbl_we     = 1'b1;
            tbl_wa     = clr_idx_ff;
            tbl_wd     = {clr_link, {FILL_W{1'b0}}};
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == ID_W'(PACKET_TOTAL - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_TBL;
            end
         end
         S_TBL: begin
            if (act_ff == ACT_POP && !bad_ff && tbl_fill != '0) begin
               state_in = S_ENT;
            end else if (out_free) begin
               fin      = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ENT: begin
            if (out_free) begin
               fin      = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      case (act_ff)
         ACT_GET_INPUT, ACT_GET_OUTPUT: begin
            if (!take_ok_ff) begin
               rsp_status_in = ST_NO_PACKET;
            end else begin
               r_fill = tbl_fill;
               if (fin) begin
                  case (src_ff)
                     POOL_EMPTY: begin
                        empty_head_in = tbl_link;
                        empty_cnt_in  = empty_cnt_ff - 1'b1;
                     end
                     POOL_PARTIAL: begin
                        part_head_in = tbl_link;
                        part_cnt_in  = part_cnt_ff - 1'b1;
                     end
                     default: begin
                        full_head_in = tbl_link;
                        full_cnt_in  = full_cnt_ff - 1'b1;
                     end
                  endcase
               end
            end
         end
         ACT_RETURN: begin
            if (bad_ff) begin
               rsp_status_in = ST_NO_PACKET;
            end else begin
               r_fill = tbl_fill;
               if (tbl_fill == '0) begin
                  dest = POOL_EMPTY;
               end else if (tbl_fill < FILL_W'(HALF)) begin
                  dest = POOL_PARTIAL;
               end
               if (fin) begin
                  tbl_we = 1'b1;
                  case (dest)
                     POOL_EMPTY: begin
                        tbl_wd        = {empty_head_ff, tbl_fill};
                        empty_head_in = id_ff;
                        if (empty_cnt_ff != CNT_W'(PACKET_TOTAL)) begin
                           empty_cnt_in = empty_cnt_ff + 1'b1;
                        end
                     end
                     POOL_PARTIAL: begin
                        tbl_wd       = {part_head_ff, tbl_fill};
                        part_head_in = id_ff;
                        if (part_cnt_ff != CNT_W'(PACKET_TOTAL)) begin
                           part_cnt_in = part_cnt_ff + 1'b1;
                        end
                     end
                     default: begin
                        tbl_wd       = {full_head_ff, tbl_fill};
                        full_head_in = id_ff;
                        if (full_cnt_ff != CNT_W'(PACKET_TOTAL)) begin
                           full_cnt_in = full_cnt_ff + 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         ACT_PUSH: begin
            if (bad_ff) begin
               rsp_status_in = ST_NO_PACKET;
            end else if (tbl_fill >= FILL_W'(ENTRIES_PER_PACKET)) begin
               rsp_status_in = ST_FULL;
               r_fill        = tbl_fill;
            end else begin
               r_fill = tbl_fill + 1'b1;
               if (fin) begin
                  ent_we = 1'b1;
                  tbl_we = 1'b1;
                  tbl_wd = {tbl_link, r_fill};
               end
            end
         end
         ACT_POP: begin
            if (bad_ff) begin
               rsp_status_in = ST_NO_PACKET;
            end else if (tbl_fill == '0) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               r_fill        = tbl_fill - 1'b1;
               rsp_popped_in = ent_rd;
               if (fin) begin
                  tbl_we = 1'b1;
                  tbl_wd = {tbl_link, r_fill};
               end
            end
         end
         default: begin
         end
      endcase

      r_gr_wide   = {5'd0, id_ff};
      r_fill_wide = {7'd0, r_fill};
      if ((act_ff == ACT_GET_INPUT || act_ff == ACT_GET_OUTPUT) && take_ok_ff) begin
         rsp_granted_in = r_gr_wide[4:0];
      end
      rsp_fill_in      = r_fill_wide[6:0];
      rsp_all_empty_in = (empty_cnt_in == CNT_W'(PACKET_TOTAL));
      if (fin) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         clr_idx_ff    <= '0;
         empty_head_ff <= ID_W'(PACKET_TOTAL - 1);
         part_head_ff  <= '0;
         full_head_ff  <= '0;
         empty_cnt_ff  <= CNT_W'(PACKET_TOTAL);
         part_cnt_ff   <= '0;
         full_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         empty_head_ff <= empty_head_in;
         part_head_ff  <= part_head_in;
         full_head_ff  <= full_head_in;
         empty_cnt_ff  <= empty_cnt_in;
         part_cnt_ff   <= part_cnt_in;
         full_cnt_ff   <= full_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // latch the item at accept; hold the result fields until the slot frees
   always_ff @(posedge clock) begin
      if (req_accept) begin
         act_ff     <= req_action;
         id_ff      <= req_is_get ? req_take_id : req_id;
         value_ff   <= req_entry_value;
         bad_ff     <= req_bad && !req_is_get;
         take_ok_ff <= req_take_ok;
         src_ff     <= req_src;
         base_ff    <= EADDR_W'(req_id * ENTRIES_PER_PACKET);
      end
      ent_ra_ff <= ent_ra;
      if (fin) begin
         rsp_granted_ff   <= rsp_granted_in;
         rsp_popped_ff    <= rsp_popped_in;
         rsp_status_ff    <= rsp_status_in;
         rsp_fill_ff      <= rsp_fill_in;
         rsp_all_empty_ff <= rsp_all_empty_in;
      end
   end

   mwpm_ram #(
      .WIDTH (TBL_W),
      .DEPTH (PACKET_TOTAL)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_wa),
      .wr_data (tbl_wd),
      .rd_addr (tbl_ra),
      .rd_data (tbl_rd)
   );

   mwpm_ram #(
      .WIDTH (64),
      .DEPTH (PACKET_TOTAL * ENTRIES_PER_PACKET)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_wa),
      .wr_data (value_ff),
      .rd_addr (ent_ra),
      .rd_data (ent_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_all_empty_ff, rsp_fill_ff, rsp_popped_ff, rsp_granted_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

[hdl/mwpm_ram.sv]
module mwpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sim/mark_work_packet_manager_tb.sv]
`timescale 1ns / 100ps

module mark_work_packet_manager_tb import mwpm_pkg::*;;

   localparam int ENTRIES      = ENTRIES_DEFAULT;
   localparam int PACKETS      = PACKETS_DEFAULT;
   localparam int HALF_FILL    = ENTRIES / 2;
   localparam int PLAN         = 0;
   localparam int CHECK        = 1;
   localparam int RANDOM_ITEMS = 1150;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PRINT_CAP    = 40;

   // actions the block treats as no-ops
   localparam logic [2:0] ACT_SPARE_LO = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;

   typedef struct packed {
      logic        drain;
      logic [2:0]  act;
      logic [4:0]  pid;
      logic [63:0] val;
   } work_request_type;

   typedef struct packed {
      logic [4:0]  granted;
      logic [63:0] popped;
      logic [1:0]  status;
      logic [6:0]  fill;
      logic        all_empty;
   } packet_reply_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   mark_work_packet_manager u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // two copies of the pool state: one steers the stimulus, one checks the block
   logic [4:0]  pool_link   [0:1][0:PACKETS-1];
   logic [4:0]  pool_head   [0:1][0:2];
   int          pool_count  [0:1][0:2];
   logic [6:0]  packet_fill [0:1][0:PACKETS-1];
   logic [63:0] entry_mem   [0:1][0:PACKETS*ENTRIES-1];

   work_request_type work_requests[$];
   packet_reply_type owed_replies[$];
   logic [4:0]       held_ids[$];
   int               planned     = 0;
   bit               drain_next  = 1'b0;
   int               error_count = 0;
   int               cycle_count = 0;

   task automatic reset_manager(input int c);
      for (int k = 0; k < PACKETS; k++) begin
         pool_link[c][k]   = (k == 0) ? 5'd0 : 5'(k - 1);
         packet_fill[c][k] = '0;
      end
      for (int p = 0; p < 3; p++) begin
         pool_head[c][p]  = '0;
         pool_count[c][p] = 0;
      end
      pool_head[c][POOL_EMPTY]  = 5'(PACKETS - 1);
      pool_count[c][POOL_EMPTY] = PACKETS;
   endtask

   task automatic take_from_pool(input int c, input logic [1:0] which, output bit got,
                                 output logic [4:0] id);
      got = 1'b0;
      id  = '0;
      if (pool_count[c][which] != 0) begin
         got = 1'b1;
         id  = pool_head[c][which];
         pool_head[c][which] = pool_link[c][id];
         pool_count[c][which]--;
      end
   endtask

   task automatic give_to_pool(input int c, input logic [1:0] which, input logic [4:0] id);
      pool_link[c][id]   = pool_head[c][which];
      pool_head[c][which] = id;
      if (pool_count[c][which] < PACKETS)
         pool_count[c][which]++;
   endtask

   task automatic advance_manager(input int c, input logic [2:0] act, input logic [4:0] pid,
                                  input logic [63:0] val, output packet_reply_type r);
      bit         got;
      logic [4:0] id;
      logic [6:0] f;
      r = '0;
      case (act)
         ACT_GET_INPUT, ACT_GET_OUTPUT: begin
            // input packets prefer the full pool, output packets the empty pool
            take_from_pool(c, (act == ACT_GET_INPUT) ? POOL_FULL : POOL_EMPTY, got, id);
            if (!got)
               take_from_pool(c, POOL_PARTIAL, got, id);
            if (got) begin
               r.granted = id;
               r.fill    = packet_fill[c][id];
            end else begin
               r.status = ST_NO_PACKET;
            end
         end
         ACT_RETURN, ACT_PUSH, ACT_POP: begin
            if (int'(pid) >= PACKETS) begin
               r.status = ST_NO_PACKET;
            end else begin
               f = packet_fill[c][pid];
               if (act == ACT_RETURN) begin
                  if (f == 0)
                     give_to_pool(c, POOL_EMPTY, pid);
                  else if (f < HALF_FILL)
                     give_to_pool(c, POOL_PARTIAL, pid);
                  else
                     give_to_pool(c, POOL_FULL, pid);
               end else if (act == ACT_PUSH) begin
                  if (f >= ENTRIES) begin
                     r.status = ST_FULL;
                  end else begin
                     entry_mem[c][pid * ENTRIES + f] = val;
                     f = f + 1'b1;
                  end
               end else begin
                  if (f == 0) begin
                     r.status = ST_EMPTY;
                  end else begin
                     f = f - 1'b1;
                     r.popped = entry_mem[c][pid * ENTRIES + f];
                  end
               end
               packet_fill[c][pid] = f;
               r.fill = f;
            end
         end
         default: ;
      endcase
      r.all_empty = (pool_count[c][POOL_EMPTY] == PACKETS);
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic queue_item(input logic [2:0] act, input logic [4:0] pid,
                             input logic [63:0] val, output packet_reply_type r);
      work_requests.push_back('{drain_next, act, pid, val});
      drain_next = 1'b0;
      advance_manager(PLAN, act, pid, val, r);
      planned++;
   endtask

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("%0t: mismatch: %s", $realtime, msg);
   endtask

   // sender: bursts of random length, random gaps in between
   work_request_type next_item;
   int               burst_left = 1;
   int               send_gap   = 0;
   bit               req_fire   = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (work_requests.size() != 0 &&
                      !(work_requests[0].drain && owed_replies.size() != 0)) begin
            next_item = work_requests.pop_front();
            req_tdata  <= {3'b000, next_item.val, next_item.pid};
            req_tuser  <= next_item.act;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 10);
               send_gap   <= $urandom_range(0, 5);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: stall mode is picked anew at random after each random-length span
   int stall_mode = 0;
   int stall_span = 0;

   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_span <= $urandom_range(50, 300);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   packet_reply_type seen, want, accepted_want;

   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            seen.granted   = rsp_tdata[4:0];
            seen.popped    = rsp_tdata[68:5];
            seen.fill      = rsp_tdata[75:69];
            seen.all_empty = rsp_tdata[76];
            seen.status    = rsp_tuser;
            if (owed_replies.size() == 0) begin
               report_mismatch("result with no item outstanding");
            end else begin
               want = owed_replies.pop_front();
               if (seen.granted !== want.granted)
                  report_mismatch($sformatf("granted_packet %0d, want %0d",
                                            seen.granted, want.granted));
               if (seen.popped !== want.popped)
                  report_mismatch($sformatf("popped_value %h, want %h",
                                            seen.popped, want.popped));
               if (seen.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d", seen.status, want.status));
               if (seen.fill !== want.fill)
                  report_mismatch($sformatf("fill_level %0d, want %0d", seen.fill, want.fill));
               if (seen.all_empty !== want.all_empty)
                  report_mismatch($sformatf("all_empty %0b, want %0b",
                                            seen.all_empty, want.all_empty));
            end
         end
         if (req_tvalid && req_tready) begin
            advance_manager(CHECK, req_tuser, req_tdata[4:0], req_tdata[68:5], accepted_want);
            owed_replies.push_back(accepted_want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[mark_work_packet_manager] ERROR");
         $finish;
      end
   end

   initial begin
      packet_reply_type r;
      logic [4:0]       id;
      logic [2:0]       act;
      int               n, k, idx, pick, target;

      reset_manager(PLAN);
      reset_manager(CHECK);

      // directed: empty pools, empty pops, value extremes, no-op actions, refiling
      queue_item(ACT_GET_INPUT, 5'd31, '0, r);
      queue_item(ACT_POP, 5'd0, '1, r);
      queue_item(ACT_GET_OUTPUT, 5'd0, '0, r);
      id = r.granted;
      queue_item(ACT_PUSH, id, '1, r);
      queue_item(ACT_PUSH, id, '0, r);
      queue_item(ACT_PUSH, id, 64'h8000_0000_0000_0001, r);
      queue_item(ACT_PUSH, id, 64'h5555_aaaa_5555_aaaa, r);
      repeat (4) queue_item(ACT_POP, id, '0, r);
      queue_item(ACT_POP, id, '0, r);
      queue_item(ACT_SPARE_LO, 5'd31, '1, r);
      queue_item(ACT_SPARE_LO + 3'd1, 5'd0, rand_word(), r);
      queue_item(ACT_SPARE_HI, 5'd17, rand_word(), r);
      queue_item(ACT_PUSH, id, rand_word(), r);
      queue_item(ACT_RETURN, id, '0, r);
      queue_item(ACT_GET_INPUT, 5'd0, '0, r);
      id = r.granted;
      queue_item(ACT_POP, id, '0, r);
      queue_item(ACT_RETURN, id, '1, r);
      queue_item(ACT_POP, 5'd31, '0, r);

      // random: producer / consumer sequences, hoarding to drain the pools, some noise
      drain_next = 1'b1;
      target = planned + RANDOM_ITEMS;
      while (planned < target) begin
         if ($urandom_range(0, 149) == 0)
            drain_next = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            queue_item(ACT_GET_OUTPUT, 5'($urandom), rand_word(), r);
            if (r.status == ST_OK) begin
               id = r.granted;
               n = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 70) : $urandom_range(1, 24);
               repeat (n) begin
                  if ($urandom_range(0, 9) == 0)
                     queue_item(ACT_POP, id, rand_word(), r);
                  else
                     queue_item(ACT_PUSH, id, rand_word(), r);
               end
               queue_item(ACT_RETURN, id, rand_word(), r);
            end else if (held_ids.size() != 0) begin
               queue_item(ACT_RETURN, held_ids.pop_front(), rand_word(), r);
            end
         end else if (pick < 65) begin
            queue_item(ACT_GET_INPUT, 5'($urandom), rand_word(), r);
            if (r.status == ST_OK) begin
               id = r.granted;
               n = $urandom_range(0, int'(r.fill) + 2);
               repeat (n) queue_item(ACT_POP, id, rand_word(), r);
               queue_item(ACT_RETURN, id, rand_word(), r);
            end
         end else if (pick < 78) begin
            k = $urandom_range(3, 36);
            repeat (k) begin
               queue_item($urandom_range(0, 1) ? ACT_GET_OUTPUT : ACT_GET_INPUT,
                          5'($urandom), rand_word(), r);
               if (r.status == ST_OK)
                  held_ids.push_back(r.granted);
            end
         end else if (pick < 92) begin
            if (held_ids.size() != 0) begin
               k = $urandom_range(1, held_ids.size());
               repeat (k) begin
                  idx = $urandom_range(0, held_ids.size() - 1);
                  id  = held_ids[idx];
                  held_ids.delete(idx);
                  repeat ($urandom_range(0, 3)) queue_item(ACT_PUSH, id, rand_word(), r);
                  queue_item(ACT_RETURN, id, rand_word(), r);
               end
            end
         end else begin
            act = 3'($urandom_range(0, 7));
            id  = 5'($urandom);
            if (act == ACT_RETURN && held_ids.size() != 0 && $urandom_range(0, 3) != 0) begin
               idx = $urandom_range(0, held_ids.size() - 1);
               id  = held_ids[idx];
               held_ids.delete(idx);
            end
            queue_item(act, id, rand_word(), r);
            if ((act == ACT_GET_INPUT || act == ACT_GET_OUTPUT) && r.status == ST_OK)
               held_ids.push_back(r.granted);
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (work_requests.size() != 0 || req_tvalid || owed_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && owed_replies.size() == 0)
         $display("[mark_work_packet_manager] OK");
      else
         $display("[mark_work_packet_manager] ERROR");
      $finish;
   end

endmodule
